/* rtl/tga_rle_packet_decoder_defines.svh */
// assertion helpers used by the decode core rtl
`ifndef TGA_RLE_PACKET_DECODER_DEFINES_SVH
`define TGA_RLE_PACKET_DECODER_DEFINES_SVH

// clocked check, off while reset is held
`define TGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next one
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  `TGA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/tga_pkg.sv */
package tga_pkg;

  // decoder phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PIXEL_BYTES  = 1'b0,
    REG_TOTAL_PIXELS = 1'b1
  } cfg_reg_e;

  localparam logic [2:0]  PIXEL_BYTES_RST  = 3'd3;
  localparam logic [31:0] TOTAL_PIXELS_RST = 32'd1;

  // packet header fields
  localparam logic [7:0] COUNT_MASK = 8'h7f;
  localparam logic [7:0] RUN_BIT    = 8'h80;

  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic [31:0] total_pixels;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        packet_end;
    logic        image_done;
    logic        clamped;
  } result_t;

  // index of the last byte of a pixel, out of range sizes pinned to 2 or 4
  function automatic logic [1:0] last_byte_idx(logic [2:0] pb);
    logic [1:0] idx;
    priority if (pb < 3'd3) begin
      idx = 2'd1;
    end else if (pb == 3'd3) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    return idx;
  endfunction

endpackage

/* rtl/tga_if.sv */
// coded byte stream
interface tga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// decoded pixel stream
interface tga_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  run_length;
  logic        packet_end;
  logic        image_done;
  logic        clamped;

  modport source (output valid, output pixel_value, output run_length,
                  output packet_end, output image_done, output clamped,
                  input ready);
  modport sink   (input valid, input pixel_value, input run_length,
                  input packet_end, input image_done, input clamped,
                  output ready);
endinterface

/* rtl/tga_cfg_regs.sv */
module tga_cfg_regs
  import tga_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  cfg_reg_e    idx_i,
  input  logic [31:0] wdata_i,
  output cfg_t        cfg_o
);

  logic [2:0]  pixel_bytes_q, pixel_bytes_d;
  logic [31:0] total_pixels_q, total_pixels_d;

  // register write decode
  always_comb begin
    pixel_bytes_d  = pixel_bytes_q;
    total_pixels_d = total_pixels_q;
    if (we_i) begin
      unique case (idx_i)
        REG_PIXEL_BYTES:  pixel_bytes_d  = wdata_i[2:0];
        REG_TOTAL_PIXELS: total_pixels_d = wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_bytes_q  <= PIXEL_BYTES_RST;
      total_pixels_q <= TOTAL_PIXELS_RST;
    end else begin
      pixel_bytes_q  <= pixel_bytes_d;
      total_pixels_q <= total_pixels_d;
    end
  end

  assign cfg_o.pixel_bytes  = pixel_bytes_q;
  assign cfg_o.total_pixels = total_pixels_q;

endmodule

/* rtl/tga_dec_core.sv */
`include "tga_rle_packet_decoder_defines.svh"

module tga_dec_core
  import tga_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output logic       emit_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  left_q, left_d;
  logic        is_run_q, is_run_d;
  logic        clamp_q, clamp_d;
  logic [31:0] asm_q, asm_d;
  logic [31:0] decoded_q, decoded_d;

  logic [7:0]  count;
  logic [31:0] remaining;
  logic [31:0] asm_new;
  logic [7:0]  run_len;
  logic [7:0]  left_after;
  logic [32:0] sum;
  logic [31:0] decoded_sat;
  logic [1:0]  last_idx;

  // datapath for the current byte
  always_comb begin
    count       = (byte_i & COUNT_MASK) + 8'd1;
    remaining   = cfg_i.total_pixels - decoded_q;
    last_idx    = last_byte_idx(cfg_i.pixel_bytes);
    asm_new     = (byte_idx_q == 2'd0) ? {24'd0, byte_i}
                                       : asm_q | ({24'd0, byte_i} << {byte_idx_q, 3'b000});
    run_len     = is_run_q ? left_q : 8'd1;
    left_after  = is_run_q ? 8'd0 : left_q - 8'd1;
    sum         = {1'b0, decoded_q} + {25'd0, run_len};
    decoded_sat = sum[32] ? 32'hffff_ffff : sum[31:0];
  end

  // result word, valid when emit_o is high
  always_comb begin
    res_o.pixel_value = asm_new;
    res_o.run_length  = run_len;
    res_o.packet_end  = (left_after == 8'd0);
    res_o.image_done  = (decoded_sat >= cfg_i.total_pixels);
    res_o.clamped     = clamp_q;
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    byte_idx_d = byte_idx_q;
    left_d     = left_q;
    is_run_d   = is_run_q;
    clamp_d    = clamp_q;
    asm_d      = asm_q;
    decoded_d  = decoded_q;
    emit_o     = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (decoded_q >= cfg_i.total_pixels) begin
            phase_d = PH_DONE;
          end else begin
            // cut an overlong packet to the pixels still owed
            if ({24'd0, count} > remaining) begin
              left_d  = remaining[7:0];
              clamp_d = 1'b1;
            end else begin
              left_d  = count;
              clamp_d = 1'b0;
            end
            is_run_d   = ((byte_i & RUN_BIT) != 8'd0);
            byte_idx_d = 2'd0;
            asm_d      = 32'd0;
            phase_d    = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          asm_d = asm_new;
          if (byte_idx_q < last_idx) begin
            byte_idx_d = byte_idx_q + 2'd1;
          end else begin
            byte_idx_d = 2'd0;
            left_d     = left_after;
            decoded_d  = decoded_sat;
            emit_o     = 1'b1;
            if (res_o.image_done) begin
              phase_d = PH_DONE;
            end else if (res_o.packet_end) begin
              phase_d = PH_HEADER;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      byte_idx_q <= 2'd0;
      left_q     <= 8'd0;
      is_run_q   <= 1'b0;
      clamp_q    <= 1'b0;
      asm_q      <= 32'd0;
      decoded_q  <= 32'd0;
    end else begin
      phase_q    <= phase_d;
      byte_idx_q <= byte_idx_d;
      left_q     <= left_d;
      is_run_q   <= is_run_d;
      clamp_q    <= clamp_d;
      asm_q      <= asm_d;
      decoded_q  <= decoded_d;
    end
  end

  // checks
  `TGA_ASSERT(a_run_ends_packet, (emit_o && res_o.run_length != 8'd1) |-> res_o.packet_end, "run result not at packet end")
  `TGA_ASSERT_NEXT(a_done_entered, emit_o && res_o.image_done, phase_q == PH_DONE, "image done but decoder still active")
  `TGA_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE, phase_q == PH_DONE, "decoder left done")
  `TGA_ASSERT(a_pixel_has_count, (phase_q == PH_PIXEL) |-> (left_q != 8'd0), "pixel phase with empty packet")

endmodule

/* rtl/tga_rle_packet_decoder.sv */
// Run-length packet decoder for truecolor image pixel data. Feed the coded
// pixel bytes on byte_i, one per clock; each run comes out on pixel_o as one
// word with its repeat count, each literal pixel as one word with count 1.
// Pixels are 2, 3 or 4 bytes (pixel_bytes register), first byte lowest.
// Decoding stops with image_done once total_pixels pixels have been counted;
// later bytes are taken and dropped until reset. The block sustains one byte
// per clock while pixel_o is not stalled: a byte is registered on entry, then
// the state update in the decode core writes the result register. That update
// of the packet and pixel counters is what sets the rate. Write the registers
// only while the block is idle. No clearing pass is needed after reset.
module tga_rle_packet_decoder
  import tga_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  tga_byte_if.sink          byte_i,
  tga_pixel_if.source       pixel_o
);

  cfg_t       cfg;
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       out_vld_q, out_vld_d;
  result_t    out_q, out_d;
  logic       out_free;
  logic       advance;
  logic       emit;
  result_t    res;

  tga_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_reg_e'(cfg_idx_i)),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // handshake between the stages
  assign out_free     = !out_vld_q || pixel_o.ready;
  assign advance      = in_vld_q && out_free;
  assign byte_i.ready = !in_vld_q || advance;

  tga_dec_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  // input and result register next values
  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (byte_i.ready) begin
      in_vld_d  = byte_i.valid;
      in_byte_d = byte_i.data_byte;
    end
    if (out_free) begin
      out_vld_d = emit;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    out_q     <= out_d;
  end

  assign pixel_o.valid       = out_vld_q;
  assign pixel_o.pixel_value = out_q.pixel_value;
  assign pixel_o.run_length  = out_q.run_length;
  assign pixel_o.packet_end  = out_q.packet_end;
  assign pixel_o.image_done  = out_q.image_done;
  assign pixel_o.clamped     = out_q.clamped;

endmodule

/* tb/tga_rle_packet_decoder_tb.sv */
module tga_rle_packet_decoder_tb;
  import tga_pkg::*;

  localparam logic [31:0] TOTAL_BIG   = 32'hFFFE_0001;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          RX_HOLD     = 400;

  // tracks the decoder state and holds the words it should produce
  class pixel_run_tracker;
    logic [2:0]  pix_bytes;
    logic [31:0] total;
    phase_e      ph;
    logic [1:0]  bidx;
    logic [7:0]  left;
    bit          is_run;
    bit          was_clamped;
    logic [31:0] asm_word;
    logic [31:0] decoded;
    result_t     pending_words[$];
    int          mismatches;

    function new();
      pix_bytes   = PIXEL_BYTES_RST;
      total       = TOTAL_PIXELS_RST;
      ph          = PH_HEADER;
      bidx        = '0;
      left        = '0;
      is_run      = 1'b0;
      was_clamped = 1'b0;
      asm_word    = '0;
      decoded     = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] v);
      if (idx == REG_PIXEL_BYTES) begin
        pix_bytes = v[2:0];
      end else begin
        total = v;
      end
    endfunction

    // one accepted byte, may queue one decoded word
    function void take_byte(logic [7:0] b);
      logic [31:0] count;
      logic [31:0] remaining;
      logic [7:0]  run;
      logic [32:0] sum;
      int          pb;
      result_t     w;
      if (ph == PH_DONE) begin
        return;
      end
      // packet header
      if (ph == PH_HEADER) begin
        count = 32'(b & COUNT_MASK) + 32'd1;
        if (decoded >= total) begin
          ph = PH_DONE;
          return;
        end
        remaining   = total - decoded;
        was_clamped = 1'b0;
        if (count > remaining) begin
          count       = remaining;
          was_clamped = 1'b1;
        end
        left     = count[7:0];
        is_run   = (b & RUN_BIT) != 8'h00;
        bidx     = '0;
        asm_word = '0;
        ph       = PH_PIXEL;
        return;
      end
      // pixel byte, size pinned to 2..4
      if (pix_bytes < 3'd2) begin
        pb = 2;
      end else if (pix_bytes > 3'd4) begin
        pb = 4;
      end else begin
        pb = int'(pix_bytes);
      end
      if (bidx == 2'd0) begin
        asm_word = 32'(b);
      end else begin
        asm_word = asm_word | (32'(b) << (8 * int'(bidx)));
      end
      if (int'(bidx) + 1 < pb) begin
        bidx = bidx + 2'd1;
        return;
      end
      bidx = '0;
      if (is_run) begin
        run  = left;
        left = '0;
      end else begin
        run  = 8'd1;
        left = left - 8'd1;
      end
      sum     = {1'b0, decoded} + {25'b0, run};
      decoded = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      w.pixel_value = asm_word;
      w.run_length  = run;
      w.packet_end  = (left == 8'd0);
      w.image_done  = (decoded >= total);
      w.clamped     = was_clamped;
      pending_words.push_back(w);
      if (w.image_done) begin
        ph = PH_DONE;
      end else if (w.packet_end) begin
        ph = PH_HEADER;
      end
    endfunction

    function void match_word(result_t got);
      result_t want;
      bit      bad;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: pix %h run %0d end %0b done %0b clamp %0b",
                   got.pixel_value, got.run_length, got.packet_end,
                   got.image_done, got.clamped);
        end
        return;
      end
      want = pending_words.pop_front();
      bad  = (got.pixel_value !== want.pixel_value) ||
             (got.run_length !== want.run_length) ||
             (got.packet_end !== want.packet_end) ||
             (got.image_done !== want.image_done) ||
             (got.clamped !== want.clamped);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word mismatch: exp pix %h run %0d end %0b done %0b clamp %0b",
                   want.pixel_value, want.run_length, want.packet_end,
                   want.image_done, want.clamped);
          $display("               got pix %h run %0d end %0b done %0b clamp %0b",
                   got.pixel_value, got.run_length, got.packet_end,
                   got.image_done, got.clamped);
        end
      end
    endfunction

    function int pending_count();
      return pending_words.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  tga_byte_if  byte_if ();
  tga_pixel_if pixel_if ();

  tga_rle_packet_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .byte_i     (byte_if),
    .pixel_o    (pixel_if)
  );

  pixel_run_tracker sb;
  int unsigned      n_bytes    = 0;
  int unsigned      cycles     = 0;
  bit               tx_no_gaps = 1'b0;
  bit               rx_no_gaps = 1'b0;
  bit               stall_req  = 1'b0;

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tga_rle_packet_decoder: mismatch");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [7:0] rand_pixel_byte();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] rand_header();
    int         r;
    logic [6:0] cnt;
    bit         run;
    run = $urandom_range(1, 0);
    r   = $urandom_range(99, 0);
    if (run) begin
      if (r < 40) cnt = 7'($urandom_range(3, 0));
      else if (r < 80) cnt = 7'($urandom_range(63, 4));
      else cnt = 7'($urandom_range(127, 64));
    end else begin
      if (r < 60) cnt = 7'($urandom_range(3, 0));
      else if (r < 90) cnt = 7'($urandom_range(15, 4));
      else if (r < 98) cnt = 7'($urandom_range(63, 16));
      else cnt = 7'($urandom_range(127, 64));
    end
    return {run, cnt};
  endfunction

  // offer one byte on the byte side and wait for its acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    @(negedge clk_i);
    while (!byte_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    sb.take_byte(b);
    n_bytes++;
  endtask

  task automatic finish_packet();
    while (sb.ph == PH_PIXEL) send_byte(rand_pixel_byte());
  endtask

  task automatic send_packet(input logic [7:0] hdr);
    send_byte(hdr);
    finish_packet();
  endtask

  // stop offering, let every expected word out and the pipeline settle
  task automatic wait_idle();
    if (byte_if.valid) byte_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic quiet_write(input cfg_reg_e idx, input logic [31:0] v);
    wait_idle();
    write_reg(idx, v);
  endtask

  function automatic logic [31:0] rand_pix_size();
    logic [31:0] v;
    if ($urandom_range(9, 0) < 7) v = 32'($urandom_range(4, 2));
    else v = 32'($urandom_range(7, 0));
    // upper bits are don't care for this register
    if ($urandom_range(4, 0) == 0) v = ($urandom & 32'hFFFF_FFF8) | v;
    return v;
  endfunction

  // receiver side: random ready, one long hold-off on request
  initial begin
    int n;
    pixel_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        pixel_if.ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
      end else begin
        if ($urandom_range(39, 0) == 0) rx_no_gaps = !rx_no_gaps;
        n = rx_no_gaps ? 0 : pick_gap();
        if (n > 0) begin
          pixel_if.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        pixel_if.ready <= 1'b1;
        repeat ($urandom_range(10, 1)) @(posedge clk_i);
      end
    end
  end

  // output monitor, sampled mid-cycle where everything is stable
  always @(negedge clk_i) begin
    result_t got;
    if (rst_ni && sb != null && pixel_if.valid && pixel_if.ready) begin
      got.pixel_value = pixel_if.pixel_value;
      got.run_length  = pixel_if.run_length;
      got.packet_end  = pixel_if.packet_end;
      got.image_done  = pixel_if.image_done;
      got.clamped     = pixel_if.clamped;
      sb.match_word(got);
    end
  end

  // main sequence
  initial begin
    int          r;
    int          k;
    int unsigned mark;
    bit          pressed;
    logic [7:0]  hdr;
    sb                = new();
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_PIXEL_BYTES;
    cfg_wdata         = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    pressed           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of sizes and counts
    write_reg(REG_PIXEL_BYTES, 32'd2);
    write_reg(REG_TOTAL_PIXELS, TOTAL_BIG);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    quiet_write(REG_PIXEL_BYTES, 32'd4);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // size below range acts as 2, above acts as 4
    quiet_write(REG_PIXEL_BYTES, 32'd0);
    send_byte(8'h85);
    send_byte(8'hA5);
    send_byte(8'h5A);
    quiet_write(REG_PIXEL_BYTES, 32'd7);
    send_packet(8'h01);
    // run cut to the pixels remaining, total raised again before its pixel
    quiet_write(REG_PIXEL_BYTES, 32'd3);
    quiet_write(REG_TOTAL_PIXELS, sb.decoded + 32'd2);
    send_byte(8'hC4);
    quiet_write(REG_TOTAL_PIXELS, 32'hFFFF_FFFF);
    finish_packet();
    // size lowered in the middle of a pixel
    quiet_write(REG_PIXEL_BYTES, 32'd4);
    send_byte(8'h00);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    quiet_write(REG_PIXEL_BYTES, 32'd2);
    send_byte(8'h44);

    // random packets
    while (n_bytes < 1650) begin
      if ($urandom_range(29, 0) == 0) tx_no_gaps = !tx_no_gaps;
      r = $urandom_range(99, 0);
      if (!pressed && n_bytes > 700) begin
        // hold the receiver off while bytes keep coming
        pressed    = 1'b1;
        tx_no_gaps = 1'b1;
        stall_req  = 1'b1;
        mark       = n_bytes;
        while (n_bytes < mark + 80) send_packet(8'h07);
        tx_no_gaps = 1'b0;
      end else if (r < 80) begin
        send_packet(rand_header());
      end else if (r < 86) begin
        quiet_write(REG_PIXEL_BYTES, rand_pix_size());
      end else if (r < 92) begin
        // packet that may pass a nearby total
        k = $urandom_range(8, 1);
        quiet_write(REG_TOTAL_PIXELS, sb.decoded + 32'(k));
        send_byte(rand_header());
        quiet_write(REG_TOTAL_PIXELS, ($urandom_range(1, 0) == 1) ? 32'hFFFF_FFFF : TOTAL_BIG);
        finish_packet();
      end else if (r < 96) begin
        // size change inside a pixel
        send_byte(rand_header());
        k = $urandom_range(3, 1);
        repeat (k) begin
          if (sb.ph == PH_PIXEL) send_byte(rand_pixel_byte());
        end
        quiet_write(REG_PIXEL_BYTES, rand_pix_size());
        finish_packet();
      end else begin
        quiet_write(REG_TOTAL_PIXELS, sb.decoded + 32'd100000 + 32'($urandom_range(1 << 20, 0)));
        send_packet(rand_header());
      end
    end

    // reach the end of the image one of three ways
    r = $urandom_range(2, 0);
    if (r == 0) begin
      quiet_write(REG_TOTAL_PIXELS, sb.decoded + 32'($urandom_range(6, 1)));
      while (sb.ph != PH_DONE) send_packet(rand_header());
    end else if (r == 1) begin
      // total lowered while a packet is open
      send_byte(8'h05);
      quiet_write(REG_TOTAL_PIXELS, sb.decoded);
      finish_packet();
    end else begin
      // header with nothing left to decode
      if ($urandom_range(1, 0) == 1) begin
        quiet_write(REG_TOTAL_PIXELS, 32'd0);
      end else begin
        quiet_write(REG_TOTAL_PIXELS, 32'($urandom_range(sb.decoded, 0)));
      end
      send_byte(rand_header());
    end

    // everything after done is dropped, writes do not revive it
    repeat (20) send_byte(8'($urandom));
    quiet_write(REG_PIXEL_BYTES, 32'd3);
    quiet_write(REG_TOTAL_PIXELS, 32'hFFFF_FFFF);
    repeat (10) send_byte(8'($urandom));
    quiet_write(REG_TOTAL_PIXELS, 32'd0);
    repeat (5) send_byte(8'($urandom));

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("tga_rle_packet_decoder: match");
    end else begin
      $display("tga_rle_packet_decoder: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tga_pkg.sv
rtl/tga_if.sv
rtl/tga_cfg_regs.sv
rtl/tga_dec_core.sv
rtl/tga_rle_packet_decoder.sv
tb/tga_rle_packet_decoder_tb.sv
